FILE: rtl/r5rp_pkg.sv
package r5rp_pkg;

    // Array geometry
    localparam int MAX_DISKS      = 8;
    localparam int BLOCK_BITS     = 24;
    localparam int DISK_W         = 3;
    localparam int DCNT_W         = 4;
    localparam int DIV_W          = $clog2(MAX_DISKS + 1);
    localparam int REM_W          = $clog2(MAX_DISKS);
    localparam int REC_W          = 16;
    localparam int MIN_DISKS      = 3;
    localparam int DISK_COUNT_RST = 4;

    // Config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DCNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILED_DISK = 1'b1;

    // Modulo pipeline: 3-bit digits, two digits per stage
    localparam int MOD_DIG_W  = 3;
    localparam int MOD_DPS    = 2;
    localparam int MOD_DIGITS = (BLOCK_BITS + MOD_DIG_W - 1) / MOD_DIG_W;
    localparam int MOD_STAGES = (MOD_DIGITS + MOD_DPS - 1) / MOD_DPS;
    localparam int MOD_STEP_W = MOD_DPS * MOD_DIG_W;
    localparam int MOD_PAD_W  = MOD_STAGES * MOD_STEP_W;
    localparam int MOD_X_W    = MOD_DIG_W + DIV_W;
    localparam int PEND_W     = $clog2(MOD_STAGES + 3) + 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_PLAN = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_LOAD    = 3'd1,
        KIND_RECOVER = 3'd2,
        KIND_MOVE    = 3'd3,
        KIND_SWAP    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MOD_OLDP = 2'd0,
        MOD_NEWP = 2'd1,
        MOD_DISK = 2'd2
    } t_mod_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT1,
        ST_EMIT2,
        ST_ACK
    } t_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [DISK_W-1:0]     disk_sel;
        logic [BLOCK_BITS-1:0] load_next_free;
        logic [BLOCK_BITS-1:0] load_free_count;
        logic [BLOCK_BITS-1:0] block_index;
    } t_in_item;

    typedef struct packed {
        t_kind                 kind;
        logic [DISK_W-1:0]     from_disk;
        logic [BLOCK_BITS-1:0] from_block;
        logic [DISK_W-1:0]     to_disk;
        logic [BLOCK_BITS-1:0] to_block;
        logic [REC_W-1:0]      record_index;
        logic                  no_space;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] next_free;
        logic [BLOCK_BITS-1:0] free_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_mod_op               op;
        logic [DISK_W-1:0]     disk;
        logic [BLOCK_BITS-1:0] next_free;
        logic [BLOCK_BITS-1:0] free_count;
    } t_mod_tag;

    typedef struct packed {
        logic [MOD_PAD_W-1:0] value;
        logic [DIV_W-1:0]     divisor;
        t_mod_tag             tag;
    } t_mod_req;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        t_mod_tag         tag;
    } t_mod_rsp;

    // One radix-8 remainder step: (rem*8 + dig) mod div, rem < div
    function automatic logic [REM_W-1:0] mod_digit(input logic [REM_W-1:0]     rem,
                                                   input logic [MOD_DIG_W-1:0] dig,
                                                   input logic [DIV_W-1:0]     div);
        logic [MOD_X_W-1:0] x;
        logic [MOD_X_W-1:0] r;
        logic [MOD_X_W-1:0] km;
        x = MOD_X_W'({rem, dig});
        r = x;
        for (int k = 1; k < (1 << MOD_DIG_W); k++) begin
            km = MOD_X_W'(k) * MOD_X_W'(div);
            if (x >= km) begin
                r = x - km;
            end
        end
        return r[REM_W-1:0];
    endfunction

    // Parity disk on the shrunken array, in old numbering
    function automatic logic [DISK_W-1:0] new_par(input logic [REM_W-1:0]  rem,
                                                  input logic [DIV_W-1:0]  m,
                                                  input logic [DISK_W-1:0] failed);
        logic [DIV_W-1:0] p;
        p = m - DIV_W'(1) - DIV_W'(rem);
        if (p >= DIV_W'(failed)) begin
            p = p + DIV_W'(1);
        end
        return p[DISK_W-1:0];
    endfunction

    function automatic logic [DISK_W-1:0] old_par(input logic [REM_W-1:0] rem,
                                                  input logic [DIV_W-1:0] n);
        logic [DIV_W-1:0] p;
        p = n - DIV_W'(1) - DIV_W'(rem);
        return p[DISK_W-1:0];
    endfunction

    // Drop the failed disk from the numbering
    function automatic logic [DISK_W-1:0] renum(input logic [DISK_W-1:0] d,
                                                input logic [DISK_W-1:0] failed);
        return (d > failed) ? d - DISK_W'(1) : d;
    endfunction

endpackage

FILE: rtl/r5rp_ram.sv
module r5rp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/r5rp_mod.sv
// Pipelined remainder by a small divisor; two radix-8 digits per stage.
module r5rp_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  r5rp_pkg::t_mod_req  i_req,
    output logic                o_valid,
    output r5rp_pkg::t_mod_rsp  o_rsp
);

    localparam int NS = r5rp_pkg::MOD_STAGES;

    r5rp_pkg::t_mod_req            r_req [NS];
    logic [r5rp_pkg::REM_W-1:0]    r_rem [NS];
    logic                          r_vld [NS];

    r5rp_pkg::t_mod_req            s_req [NS];
    logic [r5rp_pkg::REM_W-1:0]    s_rem [NS];
    logic                          s_vld [NS];
    r5rp_pkg::t_mod_req            n_req [NS];
    logic [r5rp_pkg::REM_W-1:0]    n_rem [NS];

    always_comb begin
        logic [r5rp_pkg::REM_W-1:0] c_rem;
        s_req[0] = i_req;
        s_rem[0] = '0;
        s_vld[0] = i_valid;
        for (int s = 1; s < NS; s++) begin
            s_req[s] = r_req[s-1];
            s_rem[s] = r_rem[s-1];
            s_vld[s] = r_vld[s-1];
        end
        for (int s = 0; s < NS; s++) begin
            c_rem = s_rem[s];
            for (int j = 0; j < r5rp_pkg::MOD_DPS; j++) begin
                c_rem = r5rp_pkg::mod_digit(
                    c_rem,
                    s_req[s].value[r5rp_pkg::MOD_PAD_W-1-j*r5rp_pkg::MOD_DIG_W
                                   -: r5rp_pkg::MOD_DIG_W],
                    s_req[s].divisor);
            end
            n_rem[s]       = c_rem;
            n_req[s]       = s_req[s];
            n_req[s].value = s_req[s].value << r5rp_pkg::MOD_STEP_W;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            r_req[s] <= n_req[s];
            r_rem[s] <= n_rem[s];
        end
    end

    assign o_valid   = r_vld[NS-1];
    assign o_rsp.rem = r_rem[NS-1];
    assign o_rsp.tag = r_req[NS-1].tag;

endmodule

FILE: rtl/raid5_remap_planner_core.sv
// RAID-5 shrink planner.
// Input channel (i_in_valid/o_in_ready, i_in_data) takes one item at a time:
// a load item writes one disk's next-free block and free count; a plan item
// asks for the relocation records of one stripe block. Results leave on
// o_out_valid/i_out_ready/o_out_data; one result per item, or two (recover
// then swap) when parity leaves a healthy disk. last marks the final one.
// Config is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
// must write it only while the block is idle; the block does not enforce this.
// Sequence: a load writes the table and ST_ACK sends its acknowledge. A plan
// item starts its parity remainders in ST_IDLE and ST_CHECK; ST_SCAN, which
// sets the cost, reads the n disks (n = disk count), one table read per cycle
// through the single RAM read port, each fed into the MOD_STAGES = 4 remainder
// pipeline for the parity test. Blocks from the fill line on skip those reads.
// Reset clears the FSM, the output valid flag, the record counter and the
// config registers (4 disks, disk 0 failed); the disk table is not cleared
// and must be loaded before planning. A stalled receiver holds the result in
// the output register; the FSM waits at its emit states until it drains.
module raid5_remap_planner_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  r5rp_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output r5rp_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [r5rp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [r5rp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Config registers
    logic [r5rp_pkg::DCNT_W-1:0]     r_disk_count;
    logic [r5rp_pkg::DISK_W-1:0]     r_failed;
    logic [r5rp_pkg::DIV_W-1:0]      c_n;      // effective disk count
    logic [r5rp_pkg::DIV_W-1:0]      c_m;      // disks after the shrink

    // Sequencer
    r5rp_pkg::t_state                r_state, n_state;
    logic [r5rp_pkg::DIV_W-1:0]      r_scan, n_scan;
    logic                            r_rd_vld, n_rd_vld;
    logic [r5rp_pkg::DISK_W-1:0]     r_rd_disk, n_rd_disk;
    logic                            r_none, n_none;
    logic [r5rp_pkg::BLOCK_BITS-1:0] r_blk, n_blk;
    logic [r5rp_pkg::REC_W-1:0]      r_rec, n_rec;
    logic [r5rp_pkg::PEND_W-1:0]     r_pend;

    // Remainders and allocator choice
    logic [r5rp_pkg::REM_W-1:0]      r_rem_old, r_rem_new;
    logic                            r_found;
    logic [r5rp_pkg::DISK_W-1:0]     r_best_disk;
    logic [r5rp_pkg::BLOCK_BITS-1:0] r_best_nf, r_best_fc;

    // Output register
    logic                            r_ovalid;
    r5rp_pkg::t_out_item             r_out, n_out;
    logic                            c_emit;
    logic                            c_out_free;
    logic                            c_acc;

    // Table RAM
    logic                            ram_we;
    logic [r5rp_pkg::DISK_W-1:0]     ram_waddr, ram_raddr;
    r5rp_pkg::t_entry                ram_wentry, ram_rentry;
    logic [r5rp_pkg::ENTRY_W-1:0]    ram_rdata;

    // Remainder pipeline
    logic                            mod_push;
    r5rp_pkg::t_mod_req              mod_req;
    logic                            mod_vld;
    r5rp_pkg::t_mod_rsp              mod_rsp;
    logic [r5rp_pkg::DISK_W-1:0]     c_disk_np;
    logic                            c_disk_ok;

    logic [r5rp_pkg::DISK_W-1:0]     c_oldp, c_newp;

    r5rp_ram #(
        .WIDTH (r5rp_pkg::ENTRY_W),
        .DEPTH (r5rp_pkg::MAX_DISKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_rentry = ram_rdata;

    r5rp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mod_push),
        .i_req   (mod_req),
        .o_valid (mod_vld),
        .o_rsp   (mod_rsp)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_count <= r5rp_pkg::DCNT_W'(r5rp_pkg::DISK_COUNT_RST);
            r_failed     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                r5rp_pkg::CFG_DISK_COUNT:  r_disk_count <= i_cfg_data[r5rp_pkg::DCNT_W-1:0];
                r5rp_pkg::CFG_FAILED_DISK: r_failed     <= i_cfg_data[r5rp_pkg::DISK_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate disk count into the supported range
    always_comb begin
        if (r_disk_count < r5rp_pkg::DCNT_W'(r5rp_pkg::MIN_DISKS)) begin
            c_n = r5rp_pkg::DIV_W'(r5rp_pkg::MIN_DISKS);
        end else if (r_disk_count > r5rp_pkg::DCNT_W'(r5rp_pkg::MAX_DISKS)) begin
            c_n = r5rp_pkg::DIV_W'(r5rp_pkg::MAX_DISKS);
        end else begin
            c_n = r5rp_pkg::DIV_W'(r_disk_count);
        end
        c_m = c_n - r5rp_pkg::DIV_W'(1);
    end

    assign c_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == r5rp_pkg::ST_IDLE);
    assign c_acc      = i_in_valid && o_in_ready;

    assign c_oldp = r5rp_pkg::old_par(r_rem_old, c_n);
    assign c_newp = r5rp_pkg::new_par(r_rem_new, c_m, r_failed);

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_rd_vld   = 1'b0;
        n_rd_disk  = r_rd_disk;
        n_none     = r_none;
        n_blk      = r_blk;
        n_rec      = r_rec;
        c_emit     = 1'b0;
        n_out      = '0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wentry = '0;
        ram_raddr  = r_failed;
        mod_push   = 1'b0;
        mod_req    = '0;

        case (r_state)
            r5rp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_blk = i_in_data.block_index;
                    if (i_in_data.cmd == r5rp_pkg::CMD_LOAD) begin
                        ram_we                = 1'b1;
                        ram_waddr             = i_in_data.disk_sel;
                        ram_wentry.next_free  = i_in_data.load_next_free;
                        ram_wentry.free_count = i_in_data.load_free_count;
                        n_state               = r5rp_pkg::ST_ACK;
                    end else begin
                        // failed disk's entry is read here, old parity remainder starts
                        mod_push        = 1'b1;
                        mod_req.value   = r5rp_pkg::MOD_PAD_W'(i_in_data.block_index);
                        mod_req.divisor = c_n;
                        mod_req.tag.op  = r5rp_pkg::MOD_OLDP;
                        n_state         = r5rp_pkg::ST_CHECK;
                    end
                end
            end

            r5rp_pkg::ST_CHECK: begin
                mod_push        = 1'b1;
                mod_req.value   = r5rp_pkg::MOD_PAD_W'(r_blk);
                mod_req.divisor = c_m;
                mod_req.tag.op  = r5rp_pkg::MOD_NEWP;
                n_none = (r5rp_pkg::DIV_W'(r_failed) >= c_n) ||
                         (r_blk >= ram_rentry.next_free);
                n_scan  = n_none ? c_n : '0;
                n_state = r5rp_pkg::ST_SCAN;
            end

            r5rp_pkg::ST_SCAN: begin
                ram_raddr = r_scan[r5rp_pkg::DISK_W-1:0];
                if (r_scan < c_n) begin
                    n_rd_vld  = 1'b1;
                    n_rd_disk = r_scan[r5rp_pkg::DISK_W-1:0];
                    n_scan    = r_scan + r5rp_pkg::DIV_W'(1);
                end
                if (r_rd_vld) begin
                    mod_push               = 1'b1;
                    mod_req.value          = r5rp_pkg::MOD_PAD_W'(ram_rentry.next_free);
                    mod_req.divisor        = c_m;
                    mod_req.tag.op         = r5rp_pkg::MOD_DISK;
                    mod_req.tag.disk       = r_rd_disk;
                    mod_req.tag.next_free  = ram_rentry.next_free;
                    mod_req.tag.free_count = ram_rentry.free_count;
                end
                // leave once every remainder is back
                if (r_scan >= c_n && !r_rd_vld && r_pend == '0) begin
                    n_state = r5rp_pkg::ST_EMIT1;
                end
            end

            r5rp_pkg::ST_EMIT1: begin
                if (c_out_free) begin
                    c_emit     = 1'b1;
                    n_out.last = 1'b1;
                    if (r_none) begin
                        n_out.kind = r5rp_pkg::KIND_NONE;
                        n_state    = r5rp_pkg::ST_IDLE;
                    end else begin
                        n_out.from_block   = r_blk;
                        n_out.record_index = r_rec;
                        n_out.no_space     = !r_found || (r_best_fc == '0);
                        if (r_found) begin
                            n_out.to_disk  = r5rp_pkg::renum(r_best_disk, r_failed);
                            n_out.to_block = r_best_nf;
                        end
                        if (r_found && r_best_fc != '0) begin
                            ram_we                = 1'b1;
                            ram_waddr             = r_best_disk;
                            ram_wentry.next_free  = r_best_nf + r5rp_pkg::BLOCK_BITS'(1);
                            ram_wentry.free_count = r_best_fc - r5rp_pkg::BLOCK_BITS'(1);
                        end
                        n_rec = r_rec + r5rp_pkg::REC_W'(1);
                        if (c_oldp == r_failed) begin
                            // parity sat on the failed disk: move new-parity block
                            n_out.kind      = r5rp_pkg::KIND_MOVE;
                            n_out.from_disk = c_newp;
                            n_state         = r5rp_pkg::ST_IDLE;
                        end else begin
                            n_out.kind      = r5rp_pkg::KIND_RECOVER;
                            n_out.from_disk = r_failed;
                            if (c_newp == c_oldp) begin
                                n_state = r5rp_pkg::ST_IDLE;
                            end else begin
                                n_out.last = 1'b0;
                                n_state    = r5rp_pkg::ST_EMIT2;
                            end
                        end
                    end
                end
            end

            r5rp_pkg::ST_EMIT2: begin
                if (c_out_free) begin
                    c_emit             = 1'b1;
                    n_out.kind         = r5rp_pkg::KIND_SWAP;
                    n_out.from_disk    = c_newp;
                    n_out.from_block   = r_blk;
                    n_out.to_disk      = r5rp_pkg::renum(c_oldp, r_failed);
                    n_out.to_block     = r_blk;
                    n_out.record_index = r_rec;
                    n_out.last         = 1'b1;
                    n_rec              = r_rec + r5rp_pkg::REC_W'(1);
                    n_state            = r5rp_pkg::ST_IDLE;
                end
            end

            r5rp_pkg::ST_ACK: begin
                if (c_out_free) begin
                    c_emit     = 1'b1;
                    n_out.kind = r5rp_pkg::KIND_LOAD;
                    n_out.last = 1'b1;
                    n_state    = r5rp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = r5rp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r5rp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_rec    <= '0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= n_rd_vld;
            r_rec    <= n_rec;
            r_pend   <= r_pend + r5rp_pkg::PEND_W'(mod_push) - r5rp_pkg::PEND_W'(mod_vld);
            if (c_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (c_acc) begin
                r_found <= 1'b0;
            end else if (mod_vld && mod_rsp.tag.op == r5rp_pkg::MOD_DISK && c_disk_ok) begin
                r_found <= 1'b1;
            end
        end
    end

    // Allocator: eligible disk, most free blocks, lowest index on ties
    assign c_disk_np = r5rp_pkg::new_par(mod_rsp.rem, c_m, r_failed);
    assign c_disk_ok = (mod_rsp.tag.disk != r_failed) &&
                       (mod_rsp.tag.disk != c_disk_np) &&
                       (!r_found || mod_rsp.tag.free_count > r_best_fc);

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_rd_disk <= n_rd_disk;
        r_none    <= n_none;
        r_blk     <= n_blk;
        if (c_emit) begin
            r_out <= n_out;
        end
        if (mod_vld) begin
            case (mod_rsp.tag.op)
                r5rp_pkg::MOD_OLDP: r_rem_old <= mod_rsp.rem;
                r5rp_pkg::MOD_NEWP: r_rem_new <= mod_rsp.rem;
                r5rp_pkg::MOD_DISK: begin
                    if (c_disk_ok) begin
                        r_best_disk <= mod_rsp.tag.disk;
                        r_best_nf   <= mod_rsp.tag.next_free;
                        r_best_fc   <= mod_rsp.tag.free_count;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/r5rp_checker.sv
module r5rp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input r5rp_pkg::t_in_item                   i_in_data,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input r5rp_pkg::t_out_item                  o_out_data,
    input logic                                 i_cfg_we,
    input logic [r5rp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input logic [r5rp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic c_in_acc;
    assign c_in_acc = i_in_valid && o_in_ready;

    // one item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_acc |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // ready again only after the final result of the item was produced
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.last)
        else $error("idle with a non-final result pending");

    // only a recover can be followed by another result
    a_non_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.kind == r5rp_pkg::KIND_RECOVER)
        else $error("non-final result of wrong kind");

    // load acknowledge carries nothing else
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == r5rp_pkg::KIND_LOAD |->
            o_out_data.record_index == '0 && !o_out_data.no_space &&
            o_out_data.to_block == '0 && o_out_data.from_block == '0)
        else $error("load acknowledge with payload");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind raid5_remap_planner_core r5rp_checker u_r5rp_checker (.*);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r5rp_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 5;
    localparam int ITEM_TARGET  = 1500;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 600;   // receiver hold-off that backs the block up
    localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES  = 40;    // catches stray records after the last one due
    localparam int PRINT_LIMIT  = 40;

    // ---------------------------------------------------------------- DUT hookup
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_DISK_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    raid5_remap_planner_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- bench state
    t_in_item    stripe_items[$];   // items waiting to be offered
    t_out_item   records_due[$];    // predicted records, oldest first
    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;

    int unsigned tx_idle_pct  = 0;  // chance per cycle that the sender holds back
    int unsigned rx_stall_pct = 0;  // chance per cycle that the receiver stalls
    logic        rx_hold      = 1'b0;
    logic        squeeze_req  = 1'b0;

    // Shadow of loaded next-free values, used only to aim block numbers below
    // the failed disk's fill line. Allocation never touches the failed disk.
    logic [BLOCK_BITS-1:0] aim_next_free [MAX_DISKS];

    // ---------------------------------------------------------------- predictor state
    logic [DCNT_W-1:0]     m_disk_count = DCNT_W'(DISK_COUNT_RST);
    logic [DISK_W-1:0]     m_failed     = '0;
    logic [REC_W-1:0]      m_rec        = '0;
    logic [BLOCK_BITS-1:0] m_next_free [MAX_DISKS];
    logic [BLOCK_BITS-1:0] m_free_cnt  [MAX_DISKS];

    // Disk count register is clamped into the legal array sizes
    function automatic int unsigned sat_disks(input logic [DCNT_W-1:0] dc);
        if (32'(dc) < MIN_DISKS) begin
            return MIN_DISKS;
        end
        if (32'(dc) > MAX_DISKS) begin
            return MAX_DISKS;
        end
        return 32'(dc);
    endfunction

    // Parity position on the array with the failed disk taken out, old numbering
    function automatic logic [31:0] shrunk_parity(input logic [31:0] blk,
                                                  input logic [31:0] n,
                                                  input logic [31:0] failed);
        logic [31:0] m;
        logic [31:0] p;
        m = n - 1;
        p = (m - 1) - (blk % m);
        if (p >= failed) begin
            p = p + 1;
        end
        return p;
    endfunction

    function automatic logic [31:0] drop_failed(input logic [31:0] d,
                                                input logic [31:0] failed);
        return (d > failed) ? d - 1 : d;
    endfunction

    function automatic t_out_item make_record(input t_kind kind,
                                              input logic [31:0] fd, input logic [31:0] fb,
                                              input logic [31:0] td, input logic [31:0] tb,
                                              input logic [31:0] rec,
                                              input logic ns, input logic fin);
        t_out_item r;
        r.kind         = kind;
        r.from_disk    = fd[DISK_W-1:0];
        r.from_block   = fb[BLOCK_BITS-1:0];
        r.to_disk      = td[DISK_W-1:0];
        r.to_block     = tb[BLOCK_BITS-1:0];
        r.record_index = rec[REC_W-1:0];
        r.no_space     = ns;
        r.last         = fin;
        return r;
    endfunction

    // Picks the healthy, non-parity disk with most free blocks (lowest index on
    // ties) and takes one block from it; flags no_space if none or it is empty.
    function automatic t_out_item allocate_block(input t_kind kind,
                                                 input logic [31:0] fd,
                                                 input logic [31:0] fb,
                                                 input logic [31:0] n,
                                                 input logic [31:0] failed,
                                                 input logic fin);
        logic                  found;
        logic [31:0]           best;
        logic [BLOCK_BITS-1:0] best_free;
        logic [REC_W-1:0]      rec;
        t_out_item             r;
        found     = 1'b0;
        best      = 0;
        best_free = '0;
        rec       = m_rec;
        m_rec     = m_rec + 1'b1;
        for (int d = 0; d < n; d++) begin
            if (d != failed && d != shrunk_parity(32'(m_next_free[d]), n, failed)) begin
                if (!found || m_free_cnt[d] > best_free) begin
                    found     = 1'b1;
                    best      = d;
                    best_free = m_free_cnt[d];
                end
            end
        end
        if (!found) begin
            r = make_record(kind, fd, fb, 0, 0, 32'(rec), 1'b1, fin);
        end else if (best_free == '0) begin
            r = make_record(kind, fd, fb, drop_failed(best, failed),
                            32'(m_next_free[best]), 32'(rec), 1'b1, fin);
        end else begin
            r = make_record(kind, fd, fb, drop_failed(best, failed),
                            32'(m_next_free[best]), 32'(rec), 1'b0, fin);
            m_next_free[best] = m_next_free[best] + 1'b1;
            m_free_cnt[best]  = m_free_cnt[best] - 1'b1;
        end
        return r;
    endfunction

    // Works out the records one accepted item causes and queues them
    function automatic void predict_records(input t_in_item it);
        logic [31:0] n;
        logic [31:0] f;
        logic [31:0] blk;
        logic [31:0] oldp;
        logic [31:0] newp;
        if (it.cmd == CMD_LOAD) begin
            m_next_free[it.disk_sel] = it.load_next_free;
            m_free_cnt[it.disk_sel]  = it.load_free_count;
            records_due.push_back(make_record(KIND_LOAD, 0, 0, 0, 0, 0, 1'b0, 1'b1));
            return;
        end
        n   = sat_disks(m_disk_count);
        f   = 32'(m_failed);
        blk = 32'(it.block_index);
        // failed disk outside the array, or block at or past its fill line
        if (f >= n || blk >= 32'(m_next_free[f])) begin
            records_due.push_back(make_record(KIND_NONE, 0, 0, 0, 0, 0, 1'b0, 1'b1));
            return;
        end
        oldp = (n - 1) - (blk % n);
        newp = shrunk_parity(blk, n, f);
        if (oldp == f) begin
            records_due.push_back(allocate_block(KIND_MOVE, newp, blk, n, f, 1'b1));
        end else if (newp == oldp) begin
            records_due.push_back(allocate_block(KIND_RECOVER, f, blk, n, f, 1'b1));
        end else begin
            records_due.push_back(allocate_block(KIND_RECOVER, f, blk, n, f, 1'b0));
            records_due.push_back(make_record(KIND_SWAP, newp, blk, drop_failed(oldp, f),
                                              blk, 32'(m_rec), 1'b0, 1'b1));
            m_rec = m_rec + 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- helpers
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t ns: MISMATCH %s: got %0h expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic void push_load(input logic [DISK_W-1:0] sel,
                                      input logic [BLOCK_BITS-1:0] nf,
                                      input logic [BLOCK_BITS-1:0] fc);
        t_in_item it;
        it.cmd             = CMD_LOAD;
        it.disk_sel        = sel;
        it.load_next_free  = nf;
        it.load_free_count = fc;
        it.block_index     = BLOCK_BITS'($urandom);   // don't care on a load
        aim_next_free[sel] = nf;
        stripe_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_plan(input logic [BLOCK_BITS-1:0] blk);
        t_in_item it;
        it.cmd             = CMD_PLAN;
        it.disk_sel        = DISK_W'($urandom);   // load fields are noise on a plan item
        it.load_next_free  = BLOCK_BITS'($urandom);
        it.load_free_count = BLOCK_BITS'($urandom);
        it.block_index     = blk;
        stripe_items.push_back(it);
        items_queued++;
    endfunction

    // Returns once every item is in and every predicted record has come out
    task automatic drain_results();
        @(posedge clk);
        while (stripe_items.size() != 0 || in_valid || records_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Both registers back to back; only called with the block idle
    task automatic set_array(input logic [CFG_DATA_W-1:0] dc,
                             input logic [CFG_DATA_W-1:0] fd);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DISK_COUNT;
        cfg_data <= dc;
        @(posedge clk);
        cfg_idx  <= CFG_FAILED_DISK;
        cfg_data <= fd;
        @(posedge clk);
        cfg_we   <= 1'b0;
        m_disk_count = dc;
        m_failed     = fd[DISK_W-1:0];
    endtask

    // ---------------------------------------------------------------- driver
    // Prediction happens at the accepting edge, so config seen is always current.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_records(in_data);
            end
            if (!in_valid || in_ready) begin
                if (stripe_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_data  <= stripe_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (records_due.size() == 0) begin
                    report_mismatch("record with nothing due, kind", 32'(out_data.kind), 0);
                end else begin
                    want = records_due.pop_front();
                    if (out_data.kind !== want.kind)
                        report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
                    if (out_data.from_disk !== want.from_disk)
                        report_mismatch("from_disk", 32'(out_data.from_disk),
                                        32'(want.from_disk));
                    if (out_data.from_block !== want.from_block)
                        report_mismatch("from_block", 32'(out_data.from_block),
                                        32'(want.from_block));
                    if (out_data.to_disk !== want.to_disk)
                        report_mismatch("to_disk", 32'(out_data.to_disk), 32'(want.to_disk));
                    if (out_data.to_block !== want.to_block)
                        report_mismatch("to_block", 32'(out_data.to_block),
                                        32'(want.to_block));
                    if (out_data.record_index !== want.record_index)
                        report_mismatch("record_index", 32'(out_data.record_index),
                                        32'(want.record_index));
                    if (out_data.no_space !== want.no_space)
                        report_mismatch("no_space", 32'(out_data.no_space),
                                        32'(want.no_space));
                    if (out_data.last !== want.last)
                        report_mismatch("last", 32'(out_data.last), 32'(want.last));
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- back-pressure
    // One long receiver hold-off while the sender keeps offering items.
    initial begin
        wait (squeeze_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------- watchdog
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("raid5_remap_planner_core verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus
    initial begin : stimulus
        int unsigned           ph;
        int unsigned           count;
        int unsigned           n;
        int unsigned           f;
        int unsigned           roll;
        logic [CFG_DATA_W-1:0] dc;
        logic [CFG_DATA_W-1:0] fd;
        logic [DISK_W-1:0]     sel;
        logic [BLOCK_BITS-1:0] nf;
        logic [BLOCK_BITS-1:0] fc;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: four disks, disk 0 failed. Every entry gets loaded
        // first so no plan ever reads an unwritten one.
        push_load(3'd0, 24'hFFFFFF, 24'hFFFFFF);
        push_load(3'd1, 24'h000000, 24'h000000);
        push_load(3'd2, 24'hFFFFFF, 24'h000001);  // next-free wraps when taken
        push_load(3'd3, 24'h000003, 24'h000001);  // sits on parity, never eligible
        push_load(3'd4, 24'hAAAAAA, 24'h555555);
        push_load(3'd5, 24'h555555, 24'hAAAAAA);
        push_load(3'd6, 24'h00F0F0, 24'hFFFFFF);
        push_load(3'd7, 24'h000010, 24'h000020);
        push_plan(24'h000000);  // recover, parity unchanged
        push_plan(24'h000003);  // old parity on the failed disk: move, chosen disk empty
        push_plan(24'h000004);  // parity shifts: recover then swap
        push_plan(24'h000005);
        push_plan(24'hFFFFFE);
        push_plan(24'hFFFFFF);  // at the fill line: nothing to do
        push_load(3'd1, 24'h000001, 24'hFFFFFF);
        push_plan(24'h000006);

        // Three disks, both survivors on parity at their next-free: none eligible
        drain_results();
        set_array(4'd3, 4'd0);
        push_load(3'd1, 24'h000007, 24'h000009);
        push_load(3'd2, 24'h000004, 24'h000009);
        push_plan(24'h000005);

        // Count below range clamps to three; failed disk then lies outside
        drain_results();
        set_array(4'd2, 4'd14);
        push_plan(24'h000000);

        // Count above range clamps to eight; top disk failed
        drain_results();
        set_array(4'd9, 4'd15);
        push_plan(24'h000000);
        push_plan(24'h000007);
        push_plan(24'h00000F);

        // Random phases, cycling through the idling modes
        ph = 0;
        while (items_queued < ITEM_TARGET) begin
            drain_results();
            case (ph)
                0: begin dc = 4'd3;  fd = 4'd2; end
                1: begin dc = 4'd8;  fd = 4'd7; end
                2: begin dc = 4'd8;  fd = 4'd0; end
                3: begin dc = 4'd5;  fd = 4'd3; end
                4: begin dc = 4'd15; fd = 4'd4; end
                5: begin dc = 4'd0;  fd = 4'd1; end
                6: begin dc = 4'd6;  fd = 4'd6; end   // failed disk beyond the array
                default: begin
                    dc = CFG_DATA_W'($urandom_range(15));
                    if ($urandom_range(99) < 80) begin
                        fd = CFG_DATA_W'($urandom_range(sat_disks(dc) - 1));
                    end else begin
                        fd = CFG_DATA_W'($urandom_range(7));
                    end
                    fd[3] = 1'($urandom_range(1));     // unused top bit of the write data
                end
            endcase
            set_array(dc, fd);
            case (ph % 4)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 57; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 57; end
                default: begin tx_idle_pct <= 28; rx_stall_pct <= 28; end
            endcase
            n     = sat_disks(dc);
            f     = 32'(fd[DISK_W-1:0]);
            count = (ph == 6) ? 30 : PHASE_ITEMS;
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(99) < 20) begin
                    sel  = DISK_W'($urandom_range(7));
                    roll = $urandom_range(99);
                    if (roll < 70) begin
                        nf = BLOCK_BITS'($urandom_range(255));
                    end else if (roll < 85) begin
                        nf = BLOCK_BITS'($urandom);
                    end else begin
                        nf = 24'hFFFFFF - BLOCK_BITS'($urandom_range(2));
                    end
                    roll = $urandom_range(99);
                    if (roll < 45) begin
                        fc = BLOCK_BITS'($urandom_range(3));
                    end else if (roll < 85) begin
                        fc = BLOCK_BITS'($urandom_range(2000));
                    end else begin
                        fc = BLOCK_BITS'($urandom);
                    end
                    push_load(sel, nf, fc);
                end else if (f < n && aim_next_free[f] != '0 && $urandom_range(99) < 85) begin
                    push_plan(BLOCK_BITS'($urandom_range(32'(aim_next_free[f]) - 1)));
                end else begin
                    push_plan(BLOCK_BITS'($urandom));
                end
            end
            // no idling here, so the hold-off backs the block right up
            if (ph == 4) begin
                squeeze_req <= 1'b1;
            end
            ph++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (records_due.size() != 0) begin
            report_mismatch("records never produced", records_due.size(), 0);
        end
        if (mismatches == 0) begin
            $display("raid5_remap_planner_core verification clean");
        end else begin
            $display("raid5_remap_planner_core verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/r5rp_pkg.sv
rtl/r5rp_ram.sv
rtl/r5rp_mod.sv
rtl/raid5_remap_planner_core.sv
rtl/r5rp_checker.sv
sim/tb.sv
